[rtl/rau_pkg.sv]
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

[rtl/rau_mul.sv]
module rau_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  logic [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
  end

  assign p = p_r;

endmodule

[rtl/rau_addsub.sv]
module rau_addsub
  import rau_pkg::*;
#(
  parameter int W = 65
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] res,
  output logic         cout
);

  logic [W:0]   sum;
  logic [W-1:0] b_eff;

  // For a subtraction the carry out is set when a is not below b.
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + (W+1)'(op == ALU_SUB);
  assign res   = sum[W-1:0];
  assign cout  = sum[W];

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: combines two signed fractions a/b and c/d by add,
// subtract, multiply or divide and returns the result in lowest terms.
// The input beat carries in_opcode and the four operands; only their low
// WIDTH bits are used, read as two's complement. The output beat carries the
// reduced numerator (sign-extended), the positive denominator and a status:
// ok, zero denominator or overflow, the last two with zeroed result fields.
// One item is worked on at a time and in_ready is low meanwhile. The shared
// multiplier forms the cross products in states S_MUL0 to S_MUL3, then one
// add/subtract unit runs a binary GCD loop and two bit-serial divisions of
// 2*WIDTH quotient bits each. A zero denominator or zero numerator skips the
// GCD loop and the divisions.
// The result sits in an output register; a stalled receiver holds it there,
// and a new item may be accepted while it waits, but the next result waits
// for that register to empty. Reset empties the output and returns to idle.
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_num_a,
  input  logic [31:0] in_den_a,
  input  logic [31:0] in_num_b,
  input  logic [31:0] in_den_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_num,
  output logic [30:0] out_result_den,
  output logic [1:0]  out_status
);

  localparam int DW = 2 * WIDTH;
  localparam int AW = DW + 1;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM    = DW'(1) << (WIDTH - 1);
  localparam logic [DW-1:0] LIM_M1 = LIM - DW'(1);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL0  = 12'b0000_0000_0010,
    S_MUL1  = 12'b0000_0000_0100,
    S_MUL2  = 12'b0000_0000_1000,
    S_MUL3  = 12'b0000_0001_0000,
    S_COMB  = 12'b0000_0010_0000,
    S_CHECK = 12'b0000_0100_0000,
    S_TWO   = 12'b0000_1000_0000,
    S_GCD   = 12'b0001_0000_0000,
    S_DIVN  = 12'b0010_0000_0000,
    S_DIVD  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
  endfunction

  state_t state_r, state_nxt;

  opcode_t          op_r;
  logic [WIDTH-1:0] na_r, da_r, nb_r, db_r;
  logic             na_s_r, da_s_r, nb_s_r, db_s_r;
  logic [DW-1:0]    pa_r, pb_r, pc_r;
  logic             pa_s_r, pb_s_r;
  logic [DW-1:0]    num_r, den_r, u_r, v_r, q_r, rem_r;
  logic             res_neg_r;
  logic [CW-1:0]    cnt_r;
  status_t          stat_r;

  logic             out_valid_r;
  logic [31:0]      out_num_r;
  logic [30:0]      out_den_r;
  status_t          out_stat_r;

  logic [WIDTH-1:0] mul_a, mul_b;
  logic [DW-1:0]    mul_p;
  alu_op_t          alu_op;
  logic [AW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_nb;
  logic [DW-1:0]    alu_low;
  logic             diff_zero;
  logic             sign_diff;
  logic             cnt_last;
  logic [DW-1:0]    q_step, rem_step;
  logic             slot_free;
  logic             ovf;
  logic [WIDTH-1:0] num_w;

  rau_mul #(.W(WIDTH)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  rau_addsub #(.W(AW)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .cout (alu_nb)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign alu_low   = alu_res[DW-1:0];
  assign diff_zero = (alu_low == '0);
  assign sign_diff = (pa_s_r != pb_s_r);
  assign cnt_last  = (cnt_r == CNT_LAST);
  assign slot_free = !out_valid_r || out_ready;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign q_step   = {q_r[DW-2:0], alu_nb};
  assign rem_step = alu_nb ? alu_low : {rem_r[DW-2:0], q_r[DW-1]};

  always_comb begin
    mul_a = da_r;
    mul_b = db_r;
    case (state_r)
      S_MUL0: begin
        mul_a = na_r;
        mul_b = (op_r == OP_MUL) ? nb_r : db_r;
      end
      S_MUL1: begin
        mul_a = nb_r;
        mul_b = da_r;
      end
      default: begin
        mul_a = da_r;
        mul_b = db_r;
      end
    endcase
  end

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = {1'b0, u_r};
    alu_b  = {1'b0, v_r};
    case (state_r)
      S_COMB: begin
        alu_op = sign_diff ? ALU_SUB : ALU_ADD;
        alu_a  = {1'b0, pa_r};
        alu_b  = {1'b0, pb_r};
      end
      S_DIVN, S_DIVD: begin
        alu_a = {rem_r, q_r[DW-1]};
        alu_b = {1'b0, u_r};
      end
      default: begin
        alu_a = {1'b0, u_r};
        alu_b = {1'b0, v_r};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL0;
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_COMB;
      S_COMB: begin
        if (!((op_r == OP_ADD || op_r == OP_SUB) && sign_diff && !alu_nb)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (den_r == '0 || num_r == '0) state_nxt = S_OUT;
        else                            state_nxt = S_TWO;
      end
      S_TWO:   if (num_r[0] || den_r[0]) state_nxt = S_GCD;
      S_GCD:   if (u_r[0] && v_r[0] && alu_nb && diff_zero) state_nxt = S_DIVN;
      S_DIVN:  if (cnt_last) state_nxt = S_DIVD;
      S_DIVD:  if (cnt_last) state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_r   <= opcode_t'(in_opcode);
          na_r   <= mag_of(in_num_a[WIDTH-1:0]);
          da_r   <= mag_of(in_den_a[WIDTH-1:0]);
          nb_r   <= mag_of(in_num_b[WIDTH-1:0]);
          db_r   <= mag_of(in_den_b[WIDTH-1:0]);
          na_s_r <= in_num_a[WIDTH-1];
          da_s_r <= in_den_a[WIDTH-1];
          nb_s_r <= in_num_b[WIDTH-1];
          db_s_r <= in_den_b[WIDTH-1];
        end
      end
      S_MUL1: begin
        pa_r   <= mul_p;
        pa_s_r <= (op_r == OP_MUL) ? (na_s_r ^ nb_s_r) : (na_s_r ^ db_s_r);
      end
      S_MUL2: begin
        pb_r   <= mul_p;
        pb_s_r <= nb_s_r ^ da_s_r ^ (op_r == OP_SUB);
      end
      S_MUL3: begin
        pc_r <= mul_p;
      end
      S_COMB: begin
        stat_r <= ST_OK;
        case (op_r) inside
          OP_ADD, OP_SUB: begin
            if (sign_diff && !alu_nb) begin
              // Larger magnitude goes first so that the subtraction cannot borrow.
              pa_r   <= pb_r;
              pb_r   <= pa_r;
              pa_s_r <= pb_s_r;
              pb_s_r <= pa_s_r;
            end else begin
              num_r     <= alu_low;
              den_r     <= pc_r;
              res_neg_r <= pa_s_r ^ da_s_r ^ db_s_r;
            end
          end
          OP_MUL: begin
            num_r     <= pa_r;
            den_r     <= pc_r;
            res_neg_r <= pa_s_r ^ da_s_r ^ db_s_r;
          end
          default: begin
            num_r     <= pa_r;
            den_r     <= pb_r;
            res_neg_r <= pa_s_r ^ pb_s_r;
          end
        endcase
      end
      S_CHECK: begin
        if (den_r == '0) begin
          stat_r <= ST_ZERO_DEN;
        end else if (num_r == '0) begin
          den_r <= DW'(1);
        end
      end
      S_TWO: begin
        // Common factors of two are stripped before the odd GCD loop.
        if (!num_r[0] && !den_r[0]) begin
          num_r <= num_r >> 1;
          den_r <= den_r >> 1;
        end else begin
          u_r <= num_r;
          v_r <= den_r;
        end
      end
      S_GCD: begin
        if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (!alu_nb) begin
          u_r <= v_r;
          v_r <= u_r;
        end else if (!diff_zero) begin
          u_r <= {1'b0, alu_low[DW-1:1]};
        end else begin
          q_r   <= num_r;
          rem_r <= '0;
          cnt_r <= '0;
        end
      end
      S_DIVN: begin
        if (cnt_last) begin
          num_r <= q_step;
          q_r   <= den_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else begin
          q_r   <= q_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + CW'(1);
        end
      end
      S_DIVD: begin
        q_r   <= q_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r + CW'(1);
        if (cnt_last) begin
          den_r <= q_step;
        end
      end
      default: begin
      end
    endcase
  end

  assign ovf   = (den_r > LIM_M1) || (res_neg_r ? (num_r > LIM) : (num_r > LIM_M1));
  assign num_w = res_neg_r ? (~num_r[WIDTH-1:0] + WIDTH'(1)) : num_r[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      if (stat_r == ST_ZERO_DEN) begin
        out_num_r  <= '0;
        out_den_r  <= '0;
        out_stat_r <= ST_ZERO_DEN;
      end else if (ovf) begin
        out_num_r  <= '0;
        out_den_r  <= '0;
        out_stat_r <= ST_OVERFLOW;
      end else begin
        out_num_r  <= 32'($signed(num_w));
        out_den_r  <= 31'(den_r[WIDTH-2:0]);
        out_stat_r <= ST_OK;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_num = out_num_r;
  assign out_result_den = out_den_r;
  assign out_status     = out_stat_r;

  a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_result_den != '0)
    else $error("ok result with a zero denominator");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_num == '0 && out_result_den == '0)
    else $error("failed result with non-zero fields");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVN || state_r == S_DIVD |-> u_r != '0)
    else $error("division by a zero GCD");

endmodule
